### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same edge, held off during reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/mjdc_pkg.sv
`default_nettype none

package mjdc_pkg;

    // Pipeline stages from accepted item to result strobe
    localparam int PIPE_DEPTH = 6;
    // Time path has two stages ahead of its delay line; the third stage
    // heads the line, which then waits for the date path
    localparam int TIME_DELAY = PIPE_DEPTH - 2;

    localparam int MJD_W  = 17;
    localparam int Q_W    = 9;   // year index, holds up to 511
    localparam int PROD_W = 29;  // day count times reciprocal
    localparam int YS_W   = 18;  // days before a year
    localparam int DOY_W  = 9;   // day of year

    localparam logic [MJD_W-1:0] MJD_EPOCH_1900  = 17'd15019;
    localparam logic [MJD_W-1:0] MJD_FIRST_VALID = 17'd15385;
    localparam logic [MJD_W-1:0] MJD_LAST_VALID  = 17'd88068;

    // floor(4 * 2^20 / 1461): underestimates 4d/1461 by less than one
    localparam int          RECIP_SHIFT = 20;
    localparam logic [11:0] RECIP_4_1461 = 12'd2870;
    localparam int          DAYS_4YR     = 1461;

    localparam logic [11:0] YEAR_BASE = 12'd1900;

    // Common-year day of year at which each month ends / before it starts
    localparam logic [8:0] CUM_END [0:11] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] CUM_START [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        bad;
    } t_date;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [21:0] second;
    } t_time;

endpackage

`default_nettype wire

### rtl/mjdc_date_unit.sv
`default_nettype none

module mjdc_date_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mjdc_pkg::MJD_W-1:0]    i_mjd_day,
    output logic                          o_valid,
    output mjdc_pkg::t_date               o_date
);
    import mjdc_pkg::*;

    // Days before year 1900+y, every-fourth-year rule
    function automatic logic [YS_W-1:0] year_start(input logic [Q_W-1:0] y);
        logic [Q_W-1:0] ym1;
        ym1 = y - Q_W'(1);
        return YS_W'(y) * YS_W'(365) + YS_W'(ym1 >> 2);
    endfunction

    logic [PIPE_DEPTH-1:0] r_vld;

    logic [MJD_W-1:0] r1_d, n1_d;
    logic             r1_bad, n1_bad;

    logic [MJD_W-1:0] r2_d;
    logic             r2_bad;
    logic [Q_W-1:0]   r2_q, n2_q;
    logic [PROD_W-1:0] prod;

    logic [MJD_W-1:0] r3_d;
    logic             r3_bad;
    logic [Q_W-1:0]   r3_y, n3_y;
    logic [MJD_W+3:0] four_d, q_days, rem;

    logic [MJD_W-1:0] r4_d;
    logic             r4_bad;
    logic [Q_W-1:0]   r4_y;
    logic [YS_W-1:0]  r4_ys, r4_ysp, n4_ys, n4_ysp;

    logic             r5_bad;
    logic [Q_W-1:0]   r5_y, n5_y;
    logic [DOY_W-1:0] r5_doy, n5_doy;
    logic             r5_leap, n5_leap;

    t_date            r6_date, n6_date;

    // Valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Stage 1: offset to the 1900 epoch, range check
    always_comb begin
        n1_d   = i_mjd_day - MJD_EPOCH_1900;
        n1_bad = (i_mjd_day < MJD_FIRST_VALID) || (i_mjd_day > MJD_LAST_VALID);
    end

    // Stage 2: estimate of 4d/1461 by reciprocal
    assign prod = PROD_W'(r1_d) * PROD_W'(RECIP_4_1461);
    assign n2_q = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

    // Stage 3: estimate is low by at most one, one compare fixes it
    always_comb begin
        four_d = {2'b00, r2_d, 2'b00};
        q_days = (MJD_W+4)'(r2_q) * (MJD_W+4)'(DAYS_4YR);
        rem    = four_d - q_days;
        n3_y   = (rem >= (MJD_W+4)'(DAYS_4YR)) ? r2_q + Q_W'(1) : r2_q;
    end

    // Stage 4: start of this year and of the one before
    always_comb begin
        n4_ys  = year_start(r3_y);
        n4_ysp = year_start(r3_y - Q_W'(1));
    end

    // Stage 5: step back a year when d falls on or before its start
    always_comb begin
        logic             sel;
        logic [YS_W-1:0]  diff;
        sel     = YS_W'(r4_d) <= r4_ys;
        n5_y    = sel ? r4_y - Q_W'(1) : r4_y;
        diff    = YS_W'(r4_d) - (sel ? r4_ysp : r4_ys);
        n5_doy  = diff[DOY_W-1:0];
        n5_leap = (n5_y[1:0] == 2'b00);
    end

    // Stage 6: month search over the table, day of month, range override
    always_comb begin
        logic [3:0]       mo_idx;
        logic [DOY_W-1:0] mo_start;
        logic [DOY_W-1:0] end_k;
        logic [DOY_W-1:0] day_full;
        mo_idx = 4'd11;
        for (int k = 11; k >= 0; k--) begin
            end_k = CUM_END[k] + ((r5_leap && k >= 1) ? DOY_W'(1) : DOY_W'(0));
            if (r5_doy <= end_k) begin
                mo_idx = 4'(k);
            end
        end
        mo_start = CUM_START[mo_idx]
                 + ((r5_leap && mo_idx >= 4'd2) ? DOY_W'(1) : DOY_W'(0));
        day_full = r5_doy - mo_start;
        if (r5_bad) begin
            n6_date.year  = YEAR_BASE;
            n6_date.month = 4'd1;
            n6_date.day   = 5'd1;
        end else begin
            n6_date.year  = YEAR_BASE + 12'(r5_y);
            n6_date.month = mo_idx + 4'd1;
            n6_date.day   = day_full[4:0];
        end
        n6_date.bad = r5_bad;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r1_d    <= n1_d;
        r1_bad  <= n1_bad;
        r2_d    <= r1_d;
        r2_bad  <= r1_bad;
        r2_q    <= n2_q;
        r3_d    <= r2_d;
        r3_bad  <= r2_bad;
        r3_y    <= n3_y;
        r4_d    <= r3_d;
        r4_bad  <= r3_bad;
        r4_y    <= r3_y;
        r4_ys   <= n4_ys;
        r4_ysp  <= n4_ysp;
        r5_bad  <= r4_bad;
        r5_y    <= n5_y;
        r5_doy  <= n5_doy;
        r5_leap <= n5_leap;
        r6_date <= n6_date;
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_date  = r6_date;

endmodule

`default_nettype wire

### rtl/mjdc_time_unit.sv
`default_nettype none

module mjdc_time_unit #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic [FRACTION_BITS-1:0] i_day_fraction,
    output mjdc_pkg::t_time          o_time
);
    import mjdc_pkg::*;

    localparam int FB = FRACTION_BITS;

    logic [FB+4:0] t1;
    logic [FB+5:0] t2, t3;

    logic [4:0]    r1_h;
    logic [FB-1:0] r1_rem;
    logic [4:0]    r2_h;
    logic [5:0]    r2_m;
    logic [FB-1:0] r2_rem;
    t_time         n3_time;
    t_time         r_dly [TIME_DELAY];

    // Stage 1: fraction * 24, hour is the integer part
    assign t1 = {1'b0, i_day_fraction, 4'b0000} + {2'b00, i_day_fraction, 3'b000};

    // Stage 2: remainder * 60, minute is the integer part
    assign t2 = {r1_rem, 6'b000000} - {4'b0000, r1_rem, 2'b00};

    // Stage 3: remainder * 60, seconds keep 16 fraction bits, floored
    assign t3 = {r2_rem, 6'b000000} - {4'b0000, r2_rem, 2'b00};

    always_comb begin
        n3_time.hour   = r2_h;
        n3_time.minute = r2_m;
        n3_time.second = t3[FB+5:FB-16];
    end

    // Time path runs free; the date path carries the valid bits
    always_ff @(posedge i_clk) begin
        r1_h   <= t1[FB+4:FB];
        r1_rem <= t1[FB-1:0];
        r2_h   <= r1_h;
        r2_m   <= t2[FB+5:FB];
        r2_rem <= t2[FB-1:0];
        r_dly[0] <= n3_time;
        for (int i = 1; i < TIME_DELAY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    assign o_time = r_dly[TIME_DELAY-1];

endmodule

`default_nettype wire

### rtl/mjd_to_calendar_date_time.sv
// Converts a Modified Julian Date (whole days plus a binary fraction of a
// day) to Gregorian year, month, day, hour, minute and seconds with 16
// fraction bits, floored. An item is taken at every clock edge with start
// high; busy is always low, so a new item may enter every cycle. Each result
// shows on the outputs for one cycle with o_valid high, in order, once its
// item has passed the six-stage date path (epoch offset, year estimate, year
// correction, year start, day of year, month search). Results cannot be held
// off: capture them when o_valid is high. Dates outside 1901-01-01 ..
// 2099-12-31 set o_out_of_range and report the date as 1900-01-01; the time
// of day is still converted.
`default_nettype none

module mjd_to_calendar_date_time #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [16:0]              i_mjd_day,
    input  logic [FRACTION_BITS-1:0] i_day_fraction,
    output logic                     o_valid,
    output logic [11:0]              o_year_out,
    output logic [3:0]               o_month_out,
    output logic [4:0]               o_day_out,
    output logic [4:0]               o_hour_out,
    output logic [5:0]               o_minute_out,
    output logic [21:0]              o_second_out,
    output logic                     o_out_of_range
);
    import mjdc_pkg::*;

    t_date date;
    t_time tod;
    logic  accept;

    // Fully pipelined, never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    mjdc_date_unit u_date (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_mjd_day (i_mjd_day),
        .o_valid   (o_valid),
        .o_date    (date)
    );

    mjdc_time_unit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_time (
        .i_clk          (i_clk),
        .i_day_fraction (i_day_fraction),
        .o_time         (tod)
    );

    assign o_year_out     = date.year;
    assign o_month_out    = date.month;
    assign o_day_out      = date.day;
    assign o_out_of_range = date.bad;
    assign o_hour_out     = tod.hour;
    assign o_minute_out   = tod.minute;
    assign o_second_out   = tod.second;

endmodule

`default_nettype wire

### rtl/mjdc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mjdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [11:0] o_year_out,
    input logic [3:0]  o_month_out,
    input logic [4:0]  o_day_out,
    input logic [4:0]  o_hour_out,
    input logic [5:0]  o_minute_out,
    input logic        o_out_of_range
);
    import mjdc_pkg::*;

    // Every taken item yields a strobe once it has passed the date pipeline
    `CHK_IMPLY(a_result_follows, i_clk, i_rst_n, start && !busy, ##PIPE_DEPTH o_valid, "item lost")

    // No strobe without a taken item that has come through the date pipeline
    `CHK_IMPLY(a_no_extra, i_clk, i_rst_n, o_valid, $past(start && !busy, PIPE_DEPTH), "extra result")

    // Out-of-range dates report the epoch date
    `CHK_IMPLY(a_bad_date, i_clk, i_rst_n, o_valid && o_out_of_range, o_year_out == 12'd1900 && o_month_out == 4'd1 && o_day_out == 5'd1, "bad date not fixed")

    // In-range dates stay within the calendar span
    `CHK_IMPLY(a_good_date, i_clk, i_rst_n, o_valid && !o_out_of_range, o_year_out >= 12'd1901 && o_year_out <= 12'd2099 && o_month_out >= 4'd1 && o_month_out <= 4'd12 && o_day_out >= 5'd1, "date out of span")

    // Hour and minute fields stay in range
    `CHK_NEVER(a_time_range, i_clk, i_rst_n, o_valid && (o_hour_out > 5'd23 || o_minute_out > 6'd59), "time field out of range")

endmodule

bind mjd_to_calendar_date_time mjdc_checker u_mjdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_year_out     (o_year_out),
    .o_month_out    (o_month_out),
    .o_day_out      (o_day_out),
    .o_hour_out     (o_hour_out),
    .o_minute_out   (o_minute_out),
    .o_out_of_range (o_out_of_range)
);

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mjdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned RANDOM_CALENDAR_ITEMS = 1300;
    localparam int unsigned RANDOM_RAW_ITEMS = 450;

    // One converted timestamp as the block should report it
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [21:0] second;
        logic        out_of_range;
    } t_cal_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [16:0] i_mjd_day = '0;
    logic [31:0] i_day_fraction = '0;
    logic        busy;
    logic        o_valid;
    logic [11:0] o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [21:0] o_second_out;
    logic        o_out_of_range;

    t_cal_result expected_dates[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    mjd_to_calendar_date_time u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mjd_day      (i_mjd_day),
        .i_day_fraction (i_day_fraction),
        .o_valid        (o_valid),
        .o_year_out     (o_year_out),
        .o_month_out    (o_month_out),
        .o_day_out      (o_day_out),
        .o_hour_out     (o_hour_out),
        .o_minute_out   (o_minute_out),
        .o_second_out   (o_second_out),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Calendar arithmetic, years indexed from 1900
    function automatic int unsigned month_days(input int unsigned k, input int unsigned year_idx);
        case (k)
            1:       return ((year_idx & 3) == 0) ? 29 : 28;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    // Days before the given year, every-fourth-year leap rule
    function automatic int unsigned days_before_year(input int unsigned year_idx);
        return year_idx * 365 + (year_idx - 1) / 4;
    endfunction

    function automatic logic [16:0] mjd_of(input int unsigned year_idx, input int unsigned doy);
        return 17'(int'(MJD_EPOCH_1900) + days_before_year(year_idx) + doy);
    endfunction

    function automatic t_cal_result calc_calendar(input logic [16:0] mjd, input logic [31:0] frac);
        t_cal_result r;
        int unsigned d;
        int unsigned y;
        int unsigned doy;
        int unsigned acc;
        int unsigned k;
        int unsigned len;
        bit          found;
        logic [63:0] t;
        logic [63:0] h;
        logic [63:0] m;
        r.year = 12'd1900;
        r.month = 4'd1;
        r.day = 5'd1;
        r.out_of_range = (mjd < MJD_FIRST_VALID) || (mjd > MJD_LAST_VALID);
        if (!r.out_of_range) begin
            d = 32'(mjd) - 32'(MJD_EPOCH_1900);
            y = (4 * d) / 1461;
            if (d <= days_before_year(y))
                y = y - 1;
            doy = d - days_before_year(y);
            // month search over the length table
            acc = 0;
            k = 0;
            len = 0;
            found = 1'b0;
            while (k < 12 && !found) begin
                len = month_days(k, y);
                if (acc + len >= doy) begin
                    found = 1'b1;
                end else begin
                    acc = acc + len;
                    k = k + 1;
                end
            end
            if (k > 11) begin
                k = 11;
                acc = acc - len;
            end
            r.year = 12'(1900 + y);
            r.month = 4'(k + 1);
            r.day = 5'(doy - acc);
        end
        // time of day: scale and floor at each step
        t = {32'd0, frac} * 64'd24;
        h = t >> 32;
        t = (t - (h << 32)) * 64'd60;
        m = t >> 32;
        t = (t - (m << 32)) * 64'd60;
        r.hour = h[4:0];
        r.minute = m[5:0];
        r.second = t[37:16];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Record accepted items, then check each strobed result against the oldest one
    always @(posedge i_clk) begin : score_results
        t_cal_result want;
        if (i_rst_n && start && busy === 1'b0)
            expected_dates.push_back(calc_calendar(i_mjd_day, i_day_fraction));
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_dates.size() == 0) begin
                $error("result strobe with no item outstanding");
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("year_out", 32'(want.year), 32'(o_year_out));
                check_field("month_out", 32'(want.month), 32'(o_month_out));
                check_field("day_out", 32'(want.day), 32'(o_day_out));
                check_field("hour_out", 32'(want.hour), 32'(o_hour_out));
                check_field("minute_out", 32'(want.minute), 32'(o_minute_out));
                check_field("second_out", 32'(want.second), 32'(o_second_out));
                check_field("out_of_range", 32'(want.out_of_range), 32'(o_out_of_range));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mjd_to_calendar_date_time: mismatch");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_date(input logic [16:0] mjd, input logic [31:0] frac);
        start <= 1'b1;
        i_mjd_day <= mjd;
        i_day_fraction <= frac;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Idle with junk on the data ports
    task automatic idle_for(input int unsigned n);
        if (n != 0) begin
            start <= 1'b0;
            i_mjd_day <= 17'($urandom);
            i_day_fraction <= $urandom;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Hold off until every outstanding item has come back
    task automatic wait_results_done();
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        while (expected_dates.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_dates.size() != 0) begin
            $error("%0d results never arrived", expected_dates.size());
            error_count += 32'(expected_dates.size());
            expected_dates.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Valid dates, weighted toward month ends and leap days
    function automatic logic [16:0] pick_calendar_mjd();
        int unsigned y;
        int unsigned doy;
        int unsigned mk;
        int unsigned j;
        logic [16:0] mjd;
        y = $urandom_range(1, 199);
        doy = 1;
        case ($urandom_range(0, 3))
            0: doy = $urandom_range(1, 365 + 32'((y & 3) == 0));
            1: begin
                mk = $urandom_range(0, 11);
                doy = 0;
                for (j = 0; j <= mk; j++)
                    doy += month_days(j, y);
                doy += $urandom_range(0, 1);
            end
            2: doy = 59 + $urandom_range(0, 2);
            default: return 17'($urandom_range(32'(MJD_FIRST_VALID), 32'(MJD_LAST_VALID)));
        endcase
        mjd = mjd_of(y, doy);
        if (mjd > MJD_LAST_VALID)
            mjd = MJD_LAST_VALID;
        return mjd;
    endfunction

    // Fractions, some landing right on a second boundary
    function automatic logic [31:0] pick_fraction();
        int unsigned sec;
        logic [63:0] edge_frac;
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: begin
                sec = $urandom_range(0, 86399);
                edge_frac = ((64'(sec) << 32) + 64'd86399) / 64'd86400;
                return 32'(edge_frac + $urandom_range(0, 2) - 1);
            end
            default: return ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0) ^ 32'($urandom_range(0, 7));
        endcase
    endfunction

    // Ends of the valid span and out-of-range day counts
    task automatic test_date_range_edges();
        send_date(17'd0, 32'h0000_0000);
        send_date(17'h1FFFF, 32'hFFFF_FFFF);
        send_date(MJD_EPOCH_1900, 32'h8000_0000);
        send_date(MJD_FIRST_VALID - 17'd1, 32'h1234_5678);
        send_date(MJD_FIRST_VALID, 32'h0000_0000);
        send_date(MJD_LAST_VALID, 32'hFFFF_FFFF);
        send_date(MJD_LAST_VALID + 17'd1, 32'hC000_0000);
        wait_results_done();
    endtask

    // Leap days and year ends
    task automatic test_leap_years();
        send_date(mjd_of(4, 59), $urandom);
        send_date(mjd_of(4, 60), $urandom);
        send_date(mjd_of(4, 61), $urandom);
        send_date(mjd_of(100, 60), $urandom);
        send_date(mjd_of(100, 366), $urandom);
        send_date(mjd_of(99, 365), $urandom);
        send_date(mjd_of(1, 365), $urandom);
        send_date(mjd_of(196, 366), $urandom);
        wait_results_done();
    endtask

    // Hour, minute and second boundaries of the fraction
    task automatic test_time_of_day();
        send_date(pick_calendar_mjd(), 32'h0000_0000);
        send_date(pick_calendar_mjd(), 32'hFFFF_FFFF);
        send_date(pick_calendar_mjd(), 32'h8000_0000);
        send_date(pick_calendar_mjd(), 32'd178956971);
        send_date(pick_calendar_mjd(), 32'd178956970);
        send_date(pick_calendar_mjd(), 32'hFFFF_B17E);
        send_date(pick_calendar_mjd(), 32'h5555_5555);
        send_date(pick_calendar_mjd(), 32'hAAAA_AAAA);
        wait_results_done();
    endtask

    // Valid dates with random pacing; back-to-back stretches mixed in
    task automatic test_random_calendar(input int unsigned count);
        int unsigned i;
        bit          burst;
        burst = 1'b0;
        for (i = 0; i < count; i++) begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_date(pick_calendar_mjd(), pick_fraction());
            if (i == count / 2)
                wait_results_done();
            else if (!burst)
                idle_for(pick_gap());
        end
        wait_results_done();
    endtask

    // Any day count and fraction, in or out of range
    task automatic test_random_raw(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            send_date(17'($urandom), $urandom);
            idle_for(pick_gap());
        end
        wait_results_done();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_date_range_edges();
        test_leap_years();
        test_time_of_day();
        test_random_calendar(RANDOM_CALENDAR_ITEMS);
        test_random_raw(RANDOM_RAW_ITEMS);

        if (error_count == 0)
            $display("mjd_to_calendar_date_time: match");
        else
            $display("mjd_to_calendar_date_time: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
